@@ hw/rtl/sequential_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// sequential list engine assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequential_list_engine: check failed");

// next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequential_list_engine: check failed");

`else

`define SLE_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// shared codes and controller/datapath interface types for the list engine
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_ILLEGAL  = 2'd2,
    STS_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_SCAN   = 2'd2,
    S_REPLY  = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the transaction fields
    logic update;      // run insert / delete / unused opcode
    logic match;       // build the match vector for a find
    logic scan_shift;  // step the scan by one entry
    logic scan_hit;    // record a successful find
    logic scan_miss;   // record a failed find
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_find;
    logic hit;
    logic none;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sle_ctrl
// sequencing state machine for the list engine
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire sle_pkg::sts_t sts,
  output sle_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);

  sle_pkg::state_t state;
  sle_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sle_pkg::S_IDLE: begin
        if (start) begin
          state_next = sle_pkg::S_DECODE;
        end
      end
      sle_pkg::S_DECODE: begin
        state_next = sts.is_find ? sle_pkg::S_SCAN : sle_pkg::S_REPLY;
      end
      sle_pkg::S_SCAN: begin
        if (sts.hit || sts.none) begin
          state_next = sle_pkg::S_REPLY;
        end
      end
      sle_pkg::S_REPLY: begin
        state_next = sle_pkg::S_IDLE;
      end
      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      sle_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sle_pkg::S_DECODE: begin
        cmd.match  = sts.is_find;
        cmd.update = !sts.is_find;
      end
      sle_pkg::S_SCAN: begin
        cmd.scan_hit   = sts.hit;
        cmd.scan_miss  = !sts.hit && sts.none;
        cmd.scan_shift = !sts.hit && !sts.none;
      end
      sle_pkg::S_REPLY: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/sle_datapath.sv @@
// ----------------------------------------------------------------------------
// sle_datapath
// entry cells, count, match vector scan and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module sle_datapath #(
  parameter int CAPACITY = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sle_pkg::cmd_t       cmd,
  output sle_pkg::sts_t            sts,
  input  wire logic [1:0]          opcode,
  input  wire logic [3:0]          position,
  input  wire logic signed [31:0]  value,
  output logic [1:0]               status,
  output logic [2:0]               found_index,
  output logic [3:0]               item_count
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [1:0]         op_q;
  logic [3:0]         pos_q;
  logic signed [31:0] val_q;

  logic signed [31:0] entries [CAPACITY];
  logic signed [31:0] up_src  [CAPACITY];
  logic signed [31:0] dn_src  [CAPACITY];

  logic [CW-1:0]       count;
  logic [CAPACITY-1:0] match;
  logic [IW-1:0]       scan_idx;
  sle_pkg::status_t    status_r;
  logic [IW-1:0]       found_r;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            full;
  logic            ins_bad_pos;
  logic            del_bad_pos;
  logic            do_ins;
  logic            do_del;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      pos_q <= position;
      val_q <= value;
    end
  end

  assign pos_ext     = CMPW'(pos_q);
  assign cnt_ext     = CMPW'(count);
  assign full        = (count == CW'(CAPACITY));
  assign ins_bad_pos = (pos_ext > cnt_ext);
  assign del_bad_pos = (pos_ext >= cnt_ext);
  assign do_ins      = cmd.update && (op_q == sle_pkg::OP_INSERT) && !full && !ins_bad_pos;
  assign do_del      = cmd.update && (op_q == sle_pkg::OP_DELETE) && !del_bad_pos;

  // neighbor taps for the shift up / shift down
  for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
    if (g == 0) begin : g_first
      assign up_src[g] = val_q;
    end else begin : g_rest
      assign up_src[g] = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_src[g] = entries[g];
    end else begin : g_inner
      assign dn_src[g] = entries[g+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_ins) begin
        if (CMPW'(i) == pos_ext) begin
          entries[i] <= val_q;
        end else if (CMPW'(i) > pos_ext) begin
          entries[i] <= up_src[i];
        end
      end else if (do_del) begin
        if (CMPW'(i) >= pos_ext) begin
          entries[i] <= dn_src[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + CW'(1);
    end else if (do_del) begin
      count <= count - CW'(1);
    end
  end

  // match vector: one compare per occupied cell, then scanned from index 0
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match[i] <= (entries[i] == val_q) && (CMPW'(i) < cnt_ext);
      end
      scan_idx <= '0;
    end else if (cmd.scan_shift) begin
      match    <= match >> 1;
      scan_idx <= scan_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      found_r <= '0;
      case (op_q)
        sle_pkg::OP_INSERT: begin
          if (full) begin
            status_r <= sle_pkg::STS_FULL;
          end else if (ins_bad_pos) begin
            status_r <= sle_pkg::STS_ILLEGAL;
          end else begin
            status_r <= sle_pkg::STS_OK;
          end
        end
        sle_pkg::OP_DELETE: begin
          status_r <= del_bad_pos ? sle_pkg::STS_ILLEGAL : sle_pkg::STS_OK;
        end
        default: begin
          status_r <= sle_pkg::STS_ILLEGAL;
        end
      endcase
    end else if (cmd.scan_hit) begin
      status_r <= sle_pkg::STS_OK;
      found_r  <= scan_idx;
    end else if (cmd.scan_miss) begin
      status_r <= sle_pkg::STS_NOTFOUND;
      found_r  <= '0;
    end
  end

  assign sts.is_find = (op_q == sle_pkg::OP_FIND);
  assign sts.hit     = match[0];
  assign sts.none    = ~|match;

  assign status      = status_r;
  assign found_index = 3'(found_r);
  assign item_count  = 4'(count);

endmodule

`default_nettype wire

@@ hw/rtl/sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// sequential_list_engine
// ordered list of signed 32-bit values with insert, delete and find
// ----------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low; busy then stays
// high until the result has been shown. The result (status, found_index,
// item_count) is on the ports for exactly one cycle with done high, and there
// is no way to hold it off, so the receiver must take it in that cycle.
// Insert, delete and the unused opcode pass through decode and reply; a find
// passes through decode, scan and reply. For a find the occupied cells are
// compared at once into a match vector that is then scanned one entry per
// cycle from index 0 until the first match is found or no match is left.
// item_count always shows the number of entries held after the
// transaction. With CAPACITY above 8 or 15, found_index and item_count carry
// only their low bits and positions above 15 cannot be addressed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequential_list_engine_assert.svh"

module sequential_list_engine #(
  parameter int CAPACITY = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [3:0]         position,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic [1:0]              status,
  output logic [2:0]              found_index,
  output logic [3:0]              item_count
);

  // command and status between the sequencer and the datapath
  sle_pkg::cmd_t cmd;
  sle_pkg::sts_t sts;

  // sequencer: idle, decode, scan (find only), reply
  sle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // entry cells shift up on insert and down on delete all in parallel;
  // the find compare is parallel, the first-match search is serial
  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .position    (position),
    .value       (value),
    .status      (status),
    .found_index (found_index),
    .item_count  (item_count)
  );

  // an accepted transaction keeps the block busy in the next cycle
  `SLE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // the result strobe lasts one cycle and only while busy
  `SLE_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

  // a full report only comes with the list at capacity
  `SLE_ASSERT_IMPL(a_full_count, clk, rst, done && (status == sle_pkg::STS_FULL), item_count == 4'(CAPACITY))

  // a failed find reports index zero
  `SLE_ASSERT_IMPL(a_miss_index, clk, rst, done && (status == sle_pkg::STS_NOTFOUND), found_index == 3'd0)

endmodule

`default_nettype wire
